>>> hw/rtl/majority_vote_button_debouncer_macros.svh
// Assertion macros for the button debouncer.
// No dependencies; included by the top level only.
`ifndef MAJORITY_VOTE_BUTTON_DEBOUNCER_MACROS_SVH
`define MAJORITY_VOTE_BUTTON_DEBOUNCER_MACROS_SVH

// same-cycle implication, disabled during reset
`define MVBD_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("debouncer assertion failed");

// next-cycle implication, disabled during reset
`define MVBD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("debouncer assertion failed");

`endif

>>> hw/rtl/mvbd_pkg.sv
// Shared types and constants for the majority-vote button debouncer.
// No dependencies.
package mvbd_pkg;

   typedef struct packed {
      logic        wire_level;
      logic [31:0] now_ms;
      logic        ack_read;
   } req_payload_type;

   typedef struct packed {
      logic        pressed;
      logic        change_pending;
      logic        change_event;
      logic [31:0] state_duration_ms;
      logic [31:0] previous_duration_ms;
   } rsp_payload_type;

   localparam int CSR_ADDR_BITS = 3;

   // register index, taken from paddr[2]
   localparam logic REG_CHATTER_TIME    = 1'b0;
   localparam logic REG_CLOSE_ON_GROUND = 1'b1;

   localparam logic [15:0] CHATTER_TIME_RESET    = 16'd50;
   localparam logic        CLOSE_ON_GROUND_RESET = 1'b1;

endpackage

>>> hw/rtl/majority_vote_button_debouncer.sv
// Majority-vote button debouncer: top level, one module.
// Depends on mvbd_pkg and majority_vote_button_debouncer_macros.svh.
//
//   channel  | handshake               | beat
//   ---------+-------------------------+--------------------------------
//   req      | req_valid / req_ready   | one poll (wire, time, ack)
//   rsp      | rsp_valid / rsp_ready   | one result per poll
//   csr      | APB psel/penable/pready | chatter time, polarity
//
// Flow: a poll beat is taken into the input register, evaluated in short
// logic (one 32-bit subtract and compare, one saturating add) and lands in
// the result register. One beat per cycle sustained while rsp_ready holds;
// rsp_valid is registered and rises once the beat moves into the result slot.
// Reset: synchronous, active high; clears state, config to defaults.
// Stalls: the input register keeps accepting while a result waits; when
// both registers are full, req_ready drops until rsp_ready frees the slot.
`include "majority_vote_button_debouncer_macros.svh"

module majority_vote_button_debouncer #(
   parameter int VOTE_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   // poll channel
   input  logic                          req_valid,
   output logic                          req_ready,
   input  mvbd_pkg::req_payload_type     req_data,
   // result channel
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output mvbd_pkg::rsp_payload_type     rsp_data,
   // configuration port
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [mvbd_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [31:0]                   csr_pwdata,
   output logic [31:0]                   csr_prdata,
   output logic                          csr_pready
);

   localparam logic signed [VOTE_BITS-1:0] VOTE_MAX  = {1'b0, {(VOTE_BITS-1){1'b1}}};
   localparam logic signed [VOTE_BITS-1:0] VOTE_MIN  = {1'b1, {(VOTE_BITS-1){1'b0}}};
   localparam logic signed [VOTE_BITS-1:0] VOTE_ONE  = {{(VOTE_BITS-1){1'b0}}, 1'b1};
   localparam logic signed [VOTE_BITS-1:0] VOTE_ZERO = '0;

   // ---------------- configuration registers ----------------
   logic [15:0] chatter_time_ff;
   logic        close_on_ground_ff;
   logic        csr_write;
   logic        csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[2];   // byte address 4*i, low bits ignored

   always_ff @(posedge clock) begin
      if (reset) begin
         chatter_time_ff    <= mvbd_pkg::CHATTER_TIME_RESET;
         close_on_ground_ff <= mvbd_pkg::CLOSE_ON_GROUND_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            mvbd_pkg::REG_CHATTER_TIME:    chatter_time_ff    <= csr_pwdata[15:0];
            mvbd_pkg::REG_CLOSE_ON_GROUND: close_on_ground_ff <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         mvbd_pkg::REG_CHATTER_TIME:    csr_prdata = {16'd0, chatter_time_ff};
         mvbd_pkg::REG_CLOSE_ON_GROUND: csr_prdata = {31'd0, close_on_ground_ff};
         default:                       csr_prdata = '0;
      endcase
   end

   // ---------------- input register and flow control ----------------
   logic                      in_valid_ff;
   mvbd_pkg::req_payload_type in_ff;
   logic                      rsp_valid_ff;
   mvbd_pkg::rsp_payload_type rsp_ff;
   logic                      move;      // input beat evaluated into the result slot

   assign move      = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || move;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // ---------------- debouncer state ----------------
   logic                        state_ff,  state_in;
   logic                        open_ff,   open_in;
   logic [31:0]                 start_ff,  start_in;
   logic signed [VOTE_BITS-1:0] vote_ff,   vote_in;
   logic                        flag_ff,   flag_in;
   logic [31:0]                 last_ff,   last_in;
   logic [31:0]                 prior_ff,  prior_in;

   logic                        implied_high;
   logic signed [VOTE_BITS-1:0] vote_step;
   logic [31:0]                 elapsed;
   logic                        expired;
   logic                        cand;
   logic                        flag_upd;   // flag as the result reports it
   logic                        event_in;
   logic                        commit;

   assign implied_high = state_ff ^ close_on_ground_ff;
   assign elapsed      = in_ff.now_ms - start_ff;
   assign expired      = elapsed > {16'd0, chatter_time_ff};

   // saturating vote
   always_comb begin
      if (in_ff.wire_level) begin
         vote_step = (vote_ff == VOTE_MAX) ? vote_ff : vote_ff + VOTE_ONE;
      end else begin
         vote_step = (vote_ff == VOTE_MIN) ? vote_ff : vote_ff - VOTE_ONE;
      end
   end

   // positive vote = mostly high; polarity maps it to pressed/released
   assign cand = ((vote_step > VOTE_ZERO) && !close_on_ground_ff) ||
                 ((vote_step < VOTE_ZERO) &&  close_on_ground_ff);

   always_comb begin
      state_in = state_ff;
      open_in  = open_ff;
      start_in = start_ff;
      vote_in  = vote_ff;
      flag_upd = flag_ff;
      last_in  = last_ff;
      prior_in = prior_ff;
      event_in = 1'b0;
      commit   = 1'b0;
      if (!open_ff && (in_ff.wire_level != implied_high)) begin
         // opening poll: no vote, no decision
         open_in  = 1'b1;
         start_in = in_ff.now_ms;
      end else if (open_ff) begin
         vote_in = vote_step;
         if (expired) begin
            open_in  = 1'b0;
            vote_in  = VOTE_ZERO;
            flag_upd = 1'b0;
            if ((vote_step != VOTE_ZERO) && (cand != state_ff)) begin
               commit   = 1'b1;
               prior_in = in_ff.now_ms - last_ff;
               last_in  = in_ff.now_ms;
               state_in = cand;
               flag_upd = 1'b1;
               event_in = 1'b1;
            end
         end
      end
      flag_in = flag_upd && !in_ff.ack_read;
   end

   // ---------------- control and state registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= 1'b0;
         open_ff      <= 1'b0;
         start_ff     <= '0;
         vote_ff      <= VOTE_ZERO;
         flag_ff      <= 1'b0;
         last_ff      <= '0;
         prior_ff     <= '0;
      end else begin
         if (req_valid && req_ready) begin
            in_valid_ff <= 1'b1;
         end else if (move) begin
            in_valid_ff <= 1'b0;
         end
         if (move) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (move) begin
            state_ff <= state_in;
            open_ff  <= open_in;
            start_ff <= start_in;
            vote_ff  <= vote_in;
            flag_ff  <= flag_in;
            last_ff  <= last_in;
            prior_ff <= prior_in;
         end
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_ff <= req_data;
      end
      if (move) begin
         rsp_ff.pressed              <= state_in;
         rsp_ff.change_pending       <= flag_upd;
         rsp_ff.change_event         <= event_in;
         rsp_ff.state_duration_ms    <= in_ff.now_ms - last_in;
         rsp_ff.previous_duration_ms <= prior_in;
      end
   end

   // ---------------- assertions ----------------
   `MVBD_ASSERT_NOW(a_closed_vote_zero, clock, reset, !open_ff, vote_ff == VOTE_ZERO)
   `MVBD_ASSERT_NOW(a_event_sets_flag, clock, reset, rsp_valid_ff && rsp_ff.change_event, rsp_ff.change_pending && (rsp_ff.state_duration_ms == 32'd0))
   `MVBD_ASSERT_NEXT(a_commit_flips, clock, reset, !reset && move && commit, state_ff != $past(state_ff))
   `MVBD_ASSERT_NEXT(a_held_beat_stays, clock, reset, !reset && in_valid_ff && !move, in_valid_ff)

endmodule

>>> sim/tb_majority_vote_button_debouncer.sv
// Testbench for the majority-vote button debouncer: directed and random polls
// checked against a cycle-free predictor held in a small scoreboard class.
// Depends on mvbd_pkg and the majority_vote_button_debouncer RTL.
`timescale 1ns / 100ps

module tb_majority_vote_button_debouncer;

   localparam int VOTE_BITS     = 16;
   localparam int STALL_LIMIT   = 2000;   // cycles with no beat on either channel
   localparam int RANDOM_POLLS  = 1950;
   localparam int RANDOM_PHASES = 8;

   // register settings per random phase; phase 4 is drawn at random
   localparam bit [15:0] PHASE_CHATTER [RANDOM_PHASES] =
      '{16'd0, 16'hFFFF, 16'd7, 16'd50, 16'd0, 16'd1, 16'hFFFF, 16'd20};
   localparam bit PHASE_GROUND [RANDOM_PHASES] =
      '{1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1};

   // ------------------------------------------------------------------------
   // Scoreboard: debouncer predictor plus the queue of expected result beats
   // ------------------------------------------------------------------------
   class debounce_scoreboard;
      bit [15:0]                 chatter_ms;
      bit                        ground_closes;
      bit                        state_pressed;
      bit                        win_open;
      bit [31:0]                 win_start_ms;
      longint                    vote;
      bit                        flag;
      bit [31:0]                 last_change_ms;
      bit [31:0]                 prior_dur_ms;
      mvbd_pkg::rsp_payload_type expected_q[$];
      int                        mismatches;
      int                        checked;
      int                        commits;

      function new();
         chatter_ms    = mvbd_pkg::CHATTER_TIME_RESET;
         ground_closes = mvbd_pkg::CLOSE_ON_GROUND_RESET;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function void drop_window();
         win_open     = 0;
         win_start_ms = 0;
         vote         = 0;
         flag         = 0;
      endfunction

      // one accepted poll -> one expected result beat
      function void note_poll(mvbd_pkg::req_payload_type p);
         bit                        implied_high;
         bit                        fired;
         bit                        cand;
         bit [31:0]                 elapsed;
         longint                    vmax;
         longint                    vmin;
         mvbd_pkg::rsp_payload_type want;
         implied_high = state_pressed ^ ground_closes;
         fired        = 0;
         vmax         = (longint'(1) << (VOTE_BITS - 1)) - 1;
         vmin         = -(longint'(1) << (VOTE_BITS - 1));
         if (!win_open && (p.wire_level != implied_high)) begin
            // opening poll: no vote, no decision
            win_open     = 1;
            win_start_ms = p.now_ms;
         end else if (win_open) begin
            if (p.wire_level) begin
               if (vote < vmax) vote++;
            end else if (vote > vmin) begin
               vote--;
            end
            elapsed = p.now_ms - win_start_ms;
            if (elapsed > {16'd0, chatter_ms}) begin
               cand = (vote > 0 && !ground_closes) || (vote < 0 && ground_closes);
               if (vote == 0 || cand == state_pressed) begin
                  drop_window();
               end else begin
                  prior_dur_ms   = p.now_ms - last_change_ms;
                  last_change_ms = p.now_ms;
                  state_pressed  = cand;
                  drop_window();
                  flag  = 1;
                  fired = 1;
                  commits++;
               end
            end
         end
         want.pressed              = state_pressed;
         want.change_pending       = flag;
         want.change_event         = fired;
         want.state_duration_ms    = p.now_ms - last_change_ms;
         want.previous_duration_ms = prior_dur_ms;
         expected_q.push_back(want);
         if (p.ack_read) flag = 0;
      endfunction

      function void check_result(mvbd_pkg::rsp_payload_type got);
         mvbd_pkg::rsp_payload_type want;
         if (expected_q.size() == 0) begin
            $error("result beat with no poll outstanding");
            mismatches++;
            return;
         end
         want = expected_q.pop_front();
         checked++;
         if (got.pressed !== want.pressed) begin
            $error("pressed: expected %0d, got %0d", want.pressed, got.pressed);
            mismatches++;
         end
         if (got.change_pending !== want.change_pending) begin
            $error("change_pending: expected %0d, got %0d",
                   want.change_pending, got.change_pending);
            mismatches++;
         end
         if (got.change_event !== want.change_event) begin
            $error("change_event: expected %0d, got %0d",
                   want.change_event, got.change_event);
            mismatches++;
         end
         if (got.state_duration_ms !== want.state_duration_ms) begin
            $error("state_duration_ms: expected %0d, got %0d",
                   want.state_duration_ms, got.state_duration_ms);
            mismatches++;
         end
         if (got.previous_duration_ms !== want.previous_duration_ms) begin
            $error("previous_duration_ms: expected %0d, got %0d",
                   want.previous_duration_ms, got.previous_duration_ms);
            mismatches++;
         end
      endfunction
   endclass

   // ------------------------------------------------------------------------
   // DUT hookup
   // ------------------------------------------------------------------------
   logic                               clock;
   logic                               reset;
   logic                               req_valid;
   logic                               req_ready;
   mvbd_pkg::req_payload_type          req_data;
   logic                               rsp_valid;
   logic                               rsp_ready;
   mvbd_pkg::rsp_payload_type          rsp_data;
   logic                               csr_psel;
   logic                               csr_penable;
   logic                               csr_pwrite;
   logic [mvbd_pkg::CSR_ADDR_BITS-1:0] csr_paddr;
   logic [31:0]                        csr_pwdata;
   logic [31:0]                        csr_prdata;
   logic                               csr_pready;

   debounce_scoreboard sb;

   bit        idle_on;        // random gaps on both channels
   int        stall_cycles;   // watchdog count
   int        polls_sent;
   int        settings_used;
   bit [31:0] clock_ms;       // running poll timestamp
   bit        wire_rest;      // level the wire settles at between presses

   majority_vote_button_debouncer #(.VOTE_BITS(VOTE_BITS)) i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Monitor: beats are taken at the rising edge, inputs only move on the
   // falling edge, so sampling here never races the drivers.
   always @(posedge clock) begin
      if (reset) begin
         stall_cycles <= 0;
      end else begin
         if (req_valid && req_ready) sb.note_poll(req_data);
         if (rsp_valid && rsp_ready) sb.check_result(rsp_data);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) stall_cycles <= 0;
         else stall_cycles <= stall_cycles + 1;
      end
   end

   // Watchdog: nothing moving for too long means a hang.
   initial begin
      wait (stall_cycles >= STALL_LIMIT);
      $display("Simulation FAILED");
      $finish;
   end

   // Result side backpressure: one update per falling edge.
   always @(negedge clock) begin
      rsp_ready <= !(idle_on && ($urandom_range(99) < 26));
   end

   // ------------------------------------------------------------------------
   // Drivers
   // ------------------------------------------------------------------------

   // Entered and left at a falling edge. Valid is left high after the beat;
   // the next call either drops it for a gap or loads the next payload.
   task automatic send_poll(input bit level, input bit [31:0] stamp, input bit ack);
      mvbd_pkg::req_payload_type beat;
      beat.wire_level = level;
      beat.now_ms     = stamp;
      beat.ack_read   = ack;
      while (idle_on && ($urandom_range(99) < 26)) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      do @(posedge clock); while (!req_ready);
      polls_sent++;
      @(negedge clock);
   endtask

   // Sender holds off until every outstanding result beat is back.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // APB transfer: setup, access, then back to idle on the next falling edge.
   task automatic csr_access(input logic idx, input bit wr, input logic [31:0] wdata,
                             output logic [31:0] rdata);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= wdata;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic csr_expect(input logic idx, input logic [31:0] want, input string name);
      logic [31:0] rd;
      csr_access(idx, 1'b0, 32'd0, rd);
      if (rd !== want) begin
         $error("%s readback: expected %0d, got %0d", name, want, rd);
         sb.mismatches++;
      end
   endtask

   // Only while idle. Upper pwdata bits carry junk, the block must drop them.
   task automatic set_config(input bit [15:0] chatter, input bit ground);
      logic [31:0] rd;
      logic [31:0] junk;
      drain_results();
      junk = $urandom;
      csr_access(mvbd_pkg::REG_CHATTER_TIME, 1'b1, {junk[31:16], chatter}, rd);
      csr_access(mvbd_pkg::REG_CLOSE_ON_GROUND, 1'b1, {junk[30:0], ground}, rd);
      sb.chatter_ms    = chatter;
      sb.ground_closes = ground;
      csr_expect(mvbd_pkg::REG_CHATTER_TIME, {16'd0, chatter}, "chatter_time_ms");
      csr_expect(mvbd_pkg::REG_CLOSE_ON_GROUND, {31'd0, ground}, "close_on_ground");
      settings_used++;
   endtask

   // Poll spacing scaled to the chatter time: mostly short steps so windows
   // collect votes, some long ones, some repeats, rare wraps and jumps back.
   function automatic bit [31:0] time_step(input bit [15:0] chatter);
      int        pick;
      bit [31:0] span;
      pick = $urandom_range(99);
      span = chatter / 8 + 2;
      if (pick < 70) return $urandom_range(span);
      else if (pick < 88) return $urandom_range(2 * chatter + 4);
      else if (pick < 93) return 32'd0;
      else return $urandom;
   endfunction

   task automatic timed_poll(input bit level);
      clock_ms += time_step(sb.chatter_ms);
      send_poll(level, clock_ms, $urandom_range(99) < 30);
   endtask

   // Mostly bouncy press/release edges that settle, plus noise and bursts of
   // chatter that fall back to the old level.
   task automatic random_polls(input int count);
      int start;
      int kind;
      int n;
      bit target;
      start = polls_sent;
      while (polls_sent - start < count) begin
         kind = $urandom_range(99);
         if (kind < 70) begin
            target = !wire_rest;
            n = $urandom_range(8, 1);
            repeat (n) timed_poll(($urandom_range(99) < 70) ? target : !target);
            n = $urandom_range(10, 2);
            repeat (n) timed_poll(target);
            wire_rest = target;
         end else if (kind < 85) begin
            n = $urandom_range(6, 1);
            repeat (n) timed_poll(1'($urandom_range(1)));
         end else begin
            n = $urandom_range(4, 1);
            repeat (n) timed_poll(!wire_rest);
            timed_poll(wire_rest);
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------------
   initial begin
      bit [15:0] ch;
      bit        gr;
      sb          = new();
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      idle_on     = 1'b1;
      wire_rest   = 1'b1;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      csr_expect(mvbd_pkg::REG_CHATTER_TIME, {16'd0, mvbd_pkg::CHATTER_TIME_RESET},
                 "chatter_time_ms");
      csr_expect(mvbd_pkg::REG_CLOSE_ON_GROUND, {31'd0, mvbd_pkg::CLOSE_ON_GROUND_RESET},
                 "close_on_ground");

      // Directed, at reset settings (50 ms, press pulls low).
      send_poll(1'b1, 32'd0, 1'b0);            // idle level, nothing happens
      send_poll(1'b0, 32'd10, 1'b0);           // opens window, no vote
      send_poll(1'b0, 32'd20, 1'b0);
      send_poll(1'b0, 32'd61, 1'b1);           // 51 ms > 50: press commits, ack same beat
      send_poll(1'b0, 32'd70, 1'b0);           // flag already cleared
      send_poll(1'b1, 32'd100, 1'b0);          // release window
      send_poll(1'b1, 32'd120, 1'b0);
      send_poll(1'b0, 32'd150, 1'b0);          // exactly 50 ms: no decision yet
      send_poll(1'b1, 32'd151, 1'b0);          // release commits
      send_poll(1'b0, 32'd200, 1'b0);
      send_poll(1'b0, 32'd210, 1'b0);
      send_poll(1'b1, 32'd260, 1'b0);          // tied vote: window closes, no change
      send_poll(1'b0, 32'd300, 1'b0);
      send_poll(1'b1, 32'd310, 1'b0);
      send_poll(1'b1, 32'd400, 1'b0);          // vote agrees with current state
      send_poll(1'b0, 32'd500, 1'b0);
      send_poll(1'b0, 32'd499, 1'b1);          // time ran backwards: huge elapsed
      send_poll(1'b1, 32'hFFFF_FFF0, 1'b0);    // window across the wrap
      send_poll(1'b1, 32'h0000_0020, 1'b0);
      send_poll(1'b1, 32'h0000_0030, 1'b0);    // release commits after wrap
      send_poll(1'b1, 32'hFFFF_FFFF, 1'b1);
      send_poll(1'b0, 32'd0, 1'b0);
      send_poll(1'b0, 32'd51, 1'b0);
      clock_ms  = 32'd51;
      wire_rest = 1'b0;

      // Random phases, each behind a drain and a fresh register setting.
      // Phase 2 runs with no gaps on either side.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         ch = PHASE_CHATTER[phase];
         gr = PHASE_GROUND[phase];
         if (phase == 4) begin
            ch = 16'($urandom_range(200));
            gr = 1'($urandom_range(1));
         end
         idle_on = (phase != 2);
         set_config(ch, gr);
         random_polls(RANDOM_POLLS / RANDOM_PHASES);
      end

      drain_results();
      repeat (8) @(posedge clock);
      $display("Ran %0d polls, checked %0d result beats, %0d committed changes.",
               polls_sent, sb.checked, sb.commits);
      $display("Register settings applied: %0d, chatter 0..65535, both polarities.",
               settings_used);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

>>> majority_vote_button_debouncer.f
+incdir+hw/rtl
hw/rtl/mvbd_pkg.sv
hw/rtl/majority_vote_button_debouncer.sv
sim/tb_majority_vote_button_debouncer.sv
